@@ sv/fcrs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcrs_pkg: shared types and constants
// Entry format, cell control bundle and sequencer states of the ranking sort.
// ---------------------------------------------------------------------------
package fcrs_pkg;

  localparam int unsigned COST_W  = 24;
  localparam int unsigned EPI_W   = 16;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned RANK_W  = 4;

  localparam logic [PCT_W-1:0] SUCCESS_FULL = 7'd100;
  localparam logic [EPI_W-1:0] EPI_MAX      = 16'hFFFF;

  typedef struct packed {
    logic              valid;
    logic [EPI_W-1:0]  episode;
    logic [COST_W-1:0] cost;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift_out;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_EMPTY
  } state_t;

endpackage

@@ sv/fcrs_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fcrs_cell: one slot of the ranked list
// Holds one entry; on insert takes its left neighbor's entry or the cheaper
// new record itself, and moves toward the head while the list is read out.
// ---------------------------------------------------------------------------
module fcrs_cell
  import fcrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctrl_t          ctrl,
  input  logic [EPI_W-1:0]    new_episode,
  input  logic [COST_W-1:0]   new_cost,
  input  entry_t              prev_entry,
  input  logic                prev_take,
  input  entry_t              next_entry,
  output entry_t              entry,
  output logic                take
);

  logic              valid_r, valid_nxt;
  logic [EPI_W-1:0]  episode_r, episode_nxt;
  logic [COST_W-1:0] cost_r, cost_nxt;

  // The new record belongs at or before this slot.
  assign take = !valid_r || (new_cost < cost_r);

  always_comb begin
    valid_nxt   = valid_r;
    episode_nxt = episode_r;
    cost_nxt    = cost_r;
    if (ctrl.shift_out) begin
      valid_nxt   = next_entry.valid;
      episode_nxt = next_entry.episode;
      cost_nxt    = next_entry.cost;
    end else if (ctrl.insert && take) begin
      if (prev_take) begin
        valid_nxt   = prev_entry.valid;
        episode_nxt = prev_entry.episode;
        cost_nxt    = prev_entry.cost;
      end else begin
        valid_nxt   = 1'b1;
        episode_nxt = new_episode;
        cost_nxt    = new_cost;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    episode_r <= episode_nxt;
    cost_r    <= cost_nxt;
  end

  assign entry = '{valid: valid_r, episode: episode_r, cost: cost_r};

endmodule

@@ sv/filtered_cost_ranking_sort.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// filtered_cost_ranking_sort: top-k ranking of fully successful records
// A row of insertion cells keeps the cheapest records in stable cost order
// and streams them out, head first, when the last record of a set arrives.
// ---------------------------------------------------------------------------
// Latency: a record is inserted in the cycle it is accepted; after the last
// record the first result is offered on the next cycle.
// Throughput: one record per cycle while collecting; no record is accepted
// while the N entries, or the empty marker, are read out.
// Reset: synchronous, active low; clears the list, the counters and state.
module filtered_cost_ranking_sort
  import fcrs_pkg::*;
#(
  parameter int unsigned RANK_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [PCT_W-1:0]    in_success_pct,
  input  logic [COST_W-1:0]   in_cost,
  input  logic                in_last_record,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RANK_W-1:0]   out_rank,
  output logic [EPI_W-1:0]    out_episode_index,
  output logic [COST_W-1:0]   out_ranked_cost,
  output logic                out_list_empty,
  output logic                out_last_result
);

  state_t            state_r, state_nxt;
  logic [EPI_W-1:0]  episode_r, episode_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  cell_ctrl_t        ctrl;
  logic              in_xfer, out_xfer, qualify;

  entry_t            cell_entry [RANK_DEPTH];
  logic              cell_take  [RANK_DEPTH];

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign qualify  = (in_success_pct == SUCCESS_FULL);

  assign ctrl.insert    = in_xfer && qualify;
  assign ctrl.shift_out = (state_r == ST_DRAIN) && out_ready;

  for (genvar i = 0; i < RANK_DEPTH; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_t;
    if (i == 0) begin : g_head
      assign prev_e = '0;
      assign prev_t = 1'b0;
    end else begin : g_body
      assign prev_e = cell_entry[i-1];
      assign prev_t = cell_take[i-1];
    end
    if (i == RANK_DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = cell_entry[i+1];
    end
    fcrs_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .new_episode (episode_r),
      .new_cost    (in_cost),
      .prev_entry  (prev_e),
      .prev_take   (prev_t),
      .next_entry  (next_e),
      .entry       (cell_entry[i]),
      .take        (cell_take[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_last_record) begin
          state_nxt = (cell_entry[0].valid || qualify) ? ST_DRAIN : ST_EMPTY;
        end
      end
      ST_DRAIN: begin
        if (out_ready && !cell_entry[1].valid) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready          = 1'b0;
    out_valid         = 1'b0;
    out_rank          = '0;
    out_episode_index = '0;
    out_ranked_cost   = '0;
    out_list_empty    = 1'b0;
    out_last_result   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_DRAIN: begin
        out_valid         = 1'b1;
        out_rank          = rank_r;
        out_episode_index = cell_entry[0].episode;
        out_ranked_cost   = cell_entry[0].cost;
        out_last_result   = !cell_entry[1].valid;
      end
      ST_EMPTY: begin
        out_valid       = 1'b1;
        out_list_empty  = 1'b1;
        out_last_result = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    episode_nxt = episode_r;
    rank_nxt    = rank_r;
    if (in_xfer) begin
      if (in_last_record) begin
        episode_nxt = '0;
      end else if (episode_r != EPI_MAX) begin
        episode_nxt = episode_r + 1'b1;
      end
      rank_nxt = '0;
    end else if (out_xfer) begin
      rank_nxt = rank_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      episode_r <= '0;
      rank_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      episode_r <= episode_nxt;
      rank_r    <= rank_nxt;
    end
  end

endmodule

@@ tb/filtered_cost_ranking_sort_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// filtered_cost_ranking_sort_test: self-checking testbench of the ranking sort
// Directed and random record sets are sent through the input channel. A local
// ranked list predicts every emitted entry, and each output transaction is
// compared against the oldest prediction.
// ---------------------------------------------------------------------------
module filtered_cost_ranking_sort_test;
  import fcrs_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct {
    logic [RANK_W-1:0] rank;
    logic [EPI_W-1:0]  episode;
    logic [COST_W-1:0] cost;
    logic              empty;
    logic              last;
  } ranked_result_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [PCT_W-1:0]    in_success_pct = '0;
  logic [COST_W-1:0]   in_cost        = '0;
  logic                in_last_record = 1'b0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [RANK_W-1:0]   out_rank;
  logic [EPI_W-1:0]    out_episode_index;
  logic [COST_W-1:0]   out_ranked_cost;
  logic                out_list_empty;
  logic                out_last_result;

  ranked_result_t      ranked_expect[$];
  logic [COST_W-1:0]   list_cost[DEPTH];
  logic [EPI_W-1:0]    list_episode[DEPTH];
  int unsigned         list_count   = 0;
  int unsigned         episode_next = 0;
  int unsigned         error_count  = 0;
  int unsigned         quiet_cycles = 0;
  bit                  sender_idle   = 1'b0;
  bit                  receiver_idle = 1'b0;

  filtered_cost_ranking_sort #(
    .RANK_DEPTH(DEPTH)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_success_pct    (in_success_pct),
    .in_cost           (in_cost),
    .in_last_record    (in_last_record),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rank          (out_rank),
    .out_episode_index (out_episode_index),
    .out_ranked_cost   (out_ranked_cost),
    .out_list_empty    (out_list_empty),
    .out_last_result   (out_last_result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void predict_record(input logic [PCT_W-1:0] pct,
                                         input logic [COST_W-1:0] cost,
                                         input logic last);
    int unsigned    pos;
    int unsigned    k;
    ranked_result_t res;
    pos = 0;
    if (pct == SUCCESS_FULL) begin
      while (pos < list_count && !(cost < list_cost[pos])) pos++;
      if (pos < DEPTH) begin
        k = (list_count < DEPTH) ? list_count : DEPTH - 1;
        while (k > pos) begin
          list_cost[k]    = list_cost[k-1];
          list_episode[k] = list_episode[k-1];
          k--;
        end
        list_cost[pos]    = cost;
        list_episode[pos] = episode_next[EPI_W-1:0];
        if (list_count < DEPTH) list_count++;
      end
    end
    if (episode_next < EPI_MAX) episode_next++;
    if (last) begin
      if (list_count == 0) begin
        res = '{rank: '0, episode: '0, cost: '0, empty: 1'b1, last: 1'b1};
        ranked_expect.push_back(res);
      end else begin
        for (int unsigned i = 0; i < list_count; i++) begin
          res.rank    = i[RANK_W-1:0];
          res.episode = list_episode[i];
          res.cost    = list_cost[i];
          res.empty   = 1'b0;
          res.last    = (i + 1 == list_count);
          ranked_expect.push_back(res);
        end
      end
      list_count   = 0;
      episode_next = 0;
    end
  endfunction

  task automatic send_record(input logic [PCT_W-1:0] pct, input logic [COST_W-1:0] cost,
                             input logic last);
    int unsigned gap;
    gap = sender_idle ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_success_pct <= pct;
    in_cost        <= cost;
    in_last_record <= last;
    do @(posedge clk); while (!in_ready);
    predict_record(pct, cost, last);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (ranked_expect.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_sets();
    send_record(7'd0, 24'd0, 1'b1);
    send_record(7'd99, 24'hFFFFFF, 1'b0);
    send_record(7'd127, 24'h000001, 1'b0);
    send_record(7'd101, 24'h555555, 1'b1);
  endtask

  task automatic test_cost_extremes_and_ties();
    send_record(SUCCESS_FULL, 24'hFFFFFF, 1'b0);
    send_record(SUCCESS_FULL, 24'd0, 1'b0);
    send_record(SUCCESS_FULL, 24'd5, 1'b0);
    send_record(7'd50, 24'd1, 1'b0);
    send_record(SUCCESS_FULL, 24'd5, 1'b0);
    send_record(SUCCESS_FULL, 24'hAAAAAA, 1'b1);
  endtask

  task automatic test_full_list();
    for (int i = 0; i < DEPTH; i++) send_record(SUCCESS_FULL, 24'(1000 - 10 * i), 1'b0);
    // The worst entry now costs 1000; an equal cost must be dropped.
    send_record(SUCCESS_FULL, 24'd1000, 1'b0);
    send_record(SUCCESS_FULL, 24'd995, 1'b0);
    send_record(SUCCESS_FULL, 24'd0, 1'b1);
  endtask

  task automatic test_random_sets();
    int unsigned sent;
    int unsigned set_len;
    int unsigned set_no;
    bit          no_success;
    logic [PCT_W-1:0]  pct;
    logic [COST_W-1:0] cost;
    sent   = 0;
    set_no = 0;
    while (sent < 370) begin
      sender_idle   = ($urandom_range(0, 9) < 7);
      receiver_idle = ($urandom_range(0, 9) < 7);
      set_len    = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      no_success = ($urandom_range(0, 9) == 0);
      for (int unsigned n = 0; n < set_len; n++) begin
        if (!no_success && $urandom_range(0, 99) < 65) pct = SUCCESS_FULL;
        else pct = 7'($urandom_range(0, 127));
        case ($urandom_range(0, 5))
          0: cost = 24'($urandom_range(0, 15));
          1: cost = 24'd0;
          2: cost = 24'hFFFFFF;
          3: cost = {20'hFFFFF, 4'($urandom)};
          default: cost = 24'($urandom);
        endcase
        if (pct == SUCCESS_FULL && no_success) pct = 7'd0;
        send_record(pct, cost, n + 1 == set_len);
      end
      sent += set_len;
      set_no++;
      if (set_no == 3 || $urandom_range(0, 5) == 0) wait_for_drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    test_empty_sets();
    test_cost_extremes_and_ties();
    test_full_list();
    test_random_sets();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int unsigned    stall;
    ranked_result_t want;
    bit             bad;
    @(posedge clk iff rst_n);
    forever begin
      stall = receiver_idle ? $urandom_range(0, 18) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      if (ranked_expect.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("Unexpected transaction: rank %0d episode %0d cost %0d empty %b last %b",
                   out_rank, out_episode_index, out_ranked_cost, out_list_empty,
                   out_last_result);
      end else begin
        want = ranked_expect.pop_front();
        bad  = (out_rank !== want.rank) || (out_episode_index !== want.episode) ||
               (out_ranked_cost !== want.cost) || (out_list_empty !== want.empty) ||
               (out_last_result !== want.last);
        if (bad) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display("Mismatch: expected rank %0d episode %0d cost %0d empty %b last %b, %s",
                     want.rank, want.episode, want.cost, want.empty, want.last,
                     $sformatf("got rank %0d episode %0d cost %0d empty %b last %b",
                               out_rank, out_episode_index, out_ranked_cost,
                               out_list_empty, out_last_result));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, ranked_expect.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
